FILE: design/mfc_pkg.sv
// Shared constants and the CRC-8/MAXIM byte update for the motor feedback frame checker.
`default_nettype none

package mfc_pkg;

  // Frame layout: nine body bytes followed by one CRC byte
  localparam int unsigned FrameBodyLen = 9;
  localparam logic [3:0]  FrameBody    = 4'(FrameBodyLen);

  // CRC-8/MAXIM, reflected form
  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [7:0] CrcInit = 8'h00;

  // Current scaling: raw * CurScaleNum / CurScaleDen, truncated toward zero
  localparam logic [12:0] CurScaleNum = 13'd8000;
  localparam logic [15:0] CurScaleDen = 16'd32767;
  localparam int unsigned CurDenShift = 15;

  localparam int unsigned CurWidth  = 14;
  localparam int unsigned ProdWidth = 28;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] pos_t;
  typedef logic signed [CurWidth-1:0] cur_t;

  // One byte through the reflected CRC, bit by bit
  function automatic byte_t crc8_step(byte_t crc, byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/mfc_cur_scale.sv
// Two-stage scaler from a raw signed 16-bit current word to milliamps.
`default_nettype none

module mfc_cur_scale import mfc_pkg::*; (
  input  wire logic  clk,
  input  wire byte_t raw_hi,
  input  wire byte_t raw_lo,
  output cur_t       cur_ma
);

  logic signed [15:0]   raw;
  logic [15:0]          mag;
  logic                 neg;
  logic [ProdWidth-1:0] prod;
  logic                 prod_neg;

  logic [12:0] q_est;
  logic [15:0] r_est;
  logic [12:0] q;
  cur_t        cur_next;

  always_comb begin
    raw = $signed({raw_hi, raw_lo});
    neg = raw[15];
    mag = neg ? 16'(-raw) : 16'(raw);
  end

  // Stage 1: magnitude times the scale numerator
  always_ff @(posedge clk) begin
    prod     <= ProdWidth'(mag * CurScaleNum);
    prod_neg <= neg;
  end

  // Stage 2: divide by 2^15-1. The shift underestimates the quotient by at most one,
  // and the remainder estimate stays below twice the divisor.
  always_comb begin
    q_est = prod[ProdWidth-1:CurDenShift];
    r_est = {1'b0, prod[CurDenShift-1:0]} + 16'(q_est);
    q     = (r_est >= CurScaleDen) ? q_est + 13'd1 : q_est;
    cur_next = prod_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_ff @(posedge clk) begin
    cur_ma <= cur_next;
  end

endmodule

`default_nettype wire

FILE: design/motor_feedback_frame_checker_unit.sv
// Top level of the motor feedback frame checker: framing, CRC check and result register.
//
// Usage:
//   rx_* carries received serial bytes, one word per accepted handshake
//   (rx_valid high and rx_stall low at a rising edge). Every tenth word ends a
//   frame: bytes 0 to 8 are the body, byte 9 the CRC-8/MAXIM over the body.
//   Framing is by count only; a lost or extra byte shifts every later frame.
//   fb_* carries one result word per frame: the check outcome, the running
//   error count, both CRC bytes and the fields of the last good frame.
//   Latency: the result word is valid in the cycle after the CRC byte is
//   accepted. Throughput: one byte per cycle while rx_stall is low; the current
//   scaler registers the product, then the scaled current, from stored body bytes.
//   If fb_stall holds a result, body bytes are still taken; rx_stall rises
//   only for the next CRC byte until the pending result is taken.
//   Reset (rst, synchronous) clears the byte count, the CRC, the error count
//   and the stored good frame, so results before a good frame show zeros.
`default_nettype none

module motor_feedback_frame_checker_unit import mfc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,

  input  wire logic  rx_valid,
  output logic       rx_stall,
  input  wire byte_t rx_byte,

  output logic                fb_valid,
  input  wire logic           fb_stall,
  output logic                frame_ok,
  output logic                have_feedback,
  output byte_t               motor_id,
  output byte_t               mode_byte,
  output logic signed [13:0]  current_ma,
  output logic signed [15:0]  speed_rpm,
  output logic signed [15:0]  position,
  output byte_t               temperature,
  output byte_t               crc_error_count,
  output byte_t               computed_crc,
  output byte_t               received_crc
);

  pos_t  pos;
  byte_t crc;
  byte_t frame_store [FrameBodyLen];

  // Last good frame
  byte_t              good_id;
  byte_t              good_mode;
  cur_t               good_cur;
  logic signed [15:0] good_speed;
  logic signed [15:0] good_pos;
  byte_t              good_temp;
  logic               seen;
  byte_t              err_cnt;

  cur_t  cand_cur;
  pos_t  pos_eff;
  byte_t crc_eff;
  logic  rx_take;
  logic  last_byte;
  logic  ok;
  byte_t err_cnt_next;

  mfc_cur_scale u_cur_scale (
    .clk    (clk),
    .raw_hi (frame_store[2]),
    .raw_lo (frame_store[3]),
    .cur_ma (cand_cur)
  );

  always_comb begin
    // An out-of-range count restarts the frame
    pos_eff      = (pos > FrameBody) ? '0 : pos;
    crc_eff      = (pos > FrameBody) ? CrcInit : crc;
    last_byte    = (pos_eff == FrameBody);
    rx_stall     = fb_valid & fb_stall & last_byte;
    rx_take      = rx_valid & ~rx_stall;
    ok           = (crc_eff == rx_byte);
    err_cnt_next = ok ? err_cnt : err_cnt + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      crc        <= CrcInit;
      good_id    <= '0;
      good_mode  <= '0;
      good_cur   <= '0;
      good_speed <= '0;
      good_pos   <= '0;
      good_temp  <= '0;
      seen       <= 1'b0;
      err_cnt    <= '0;
      fb_valid   <= 1'b0;
    end else begin
      if (rx_take && last_byte) begin
        fb_valid <= 1'b1;
      end else if (fb_valid && !fb_stall) begin
        fb_valid <= 1'b0;
      end
      if (rx_take) begin
        if (last_byte) begin
          pos      <= '0;
          crc      <= CrcInit;
          err_cnt  <= err_cnt_next;
          if (ok) begin
            good_id    <= frame_store[0];
            good_mode  <= frame_store[1];
            good_cur   <= cand_cur;
            good_speed <= $signed({frame_store[4], frame_store[5]});
            good_pos   <= $signed({frame_store[6], frame_store[7]});
            good_temp  <= frame_store[8];
            seen       <= 1'b1;
          end
        end else begin
          pos <= pos_eff + 4'd1;
          crc <= crc8_step(crc_eff, rx_byte);
        end
      end
    end
  end

  // Body bytes and result payload
  always_ff @(posedge clk) begin
    if (rx_take && !last_byte) begin
      frame_store[pos_eff] <= rx_byte;
    end
    if (rx_take && last_byte) begin
      frame_ok        <= ok;
      have_feedback   <= ok | seen;
      motor_id        <= ok ? frame_store[0] : good_id;
      mode_byte       <= ok ? frame_store[1] : good_mode;
      current_ma      <= ok ? cand_cur : good_cur;
      speed_rpm       <= ok ? $signed({frame_store[4], frame_store[5]}) : good_speed;
      position        <= ok ? $signed({frame_store[6], frame_store[7]}) : good_pos;
      temperature     <= ok ? frame_store[8] : good_temp;
      crc_error_count <= err_cnt_next;
      computed_crc    <= crc_eff;
      received_crc    <= rx_byte;
    end
  end

  a_last_byte_gives_result: assert property (@(posedge clk) disable iff (rst)
    rx_take && last_byte |=> fb_valid)
    else $error("CRC byte accepted without a result");

  a_stall_only_on_crc_byte: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> (pos == FrameBody) && fb_valid)
    else $error("input stalled outside a blocked frame end");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    pos <= FrameBody)
    else $error("byte position out of range");

  a_feedback_matches_seen: assert property (@(posedge clk) disable iff (rst)
    fb_valid |-> (have_feedback == seen) && (crc_error_count == err_cnt))
    else $error("result disagrees with stored state");

  a_error_count_step: assert property (@(posedge clk) disable iff (rst)
    rx_take && last_byte && !ok |=> err_cnt == $past(err_cnt) + 8'd1)
    else $error("error count did not advance on a failed frame");

endmodule

`default_nettype wire
